// ===== rtl/swc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swc_pkg;

    // Window and number format
    localparam int MAX_PIXELS = 4096;
    localparam int FRAC_BITS  = 14;
    localparam int Q_BITS     = 30;

    // Field and accumulator widths
    localparam int PIX_W = 8;
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W = 20;
    localparam int SQ_W  = 28;
    localparam int SIM_W = 16;

    // Shared multiplier and datapath widths
    localparam int MUL_A_W   = 42;
    localparam int MUL_B_W   = 20;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int PROD_W    = 55;
    localparam int VAR_W     = 42;
    localparam int N2_W      = 2 * CNT_W;
    localparam int DIV_W     = 55;
    localparam int Q_W       = Q_BITS + 1;
    localparam int CNT_DIV_W = $clog2(Q_BITS + 1);
    localparam int CQ_HI_W   = Q_W - MUL_B_W;

    // Final product and rounding
    localparam int PACC_W = 2 * Q_W - 1;
    localparam int RND_SH = 2 * Q_BITS - FRAC_BITS;
    localparam int MAG_W  = PACC_W + 1 - RND_SH;
    localparam int MAGX_W = (MAG_W > SIM_W + 1) ? MAG_W : SIM_W + 1;

    localparam logic [Q_W-1:0]    Q_ONE       = {1'b1, {Q_BITS{1'b0}}};
    localparam logic [PACC_W:0]   RND_HALF    = (PACC_W + 1)'(1) << (RND_SH - 1);
    localparam logic [MAGX_W-1:0] SIM_POS_LIM = MAGX_W'((1 << (SIM_W - 1)) - 1);
    localparam logic [MAGX_W-1:0] SIM_NEG_LIM = MAGX_W'(1 << (SIM_W - 1));

    // Stabilizing constants and scale, all terms scaled by 10000 * n^2
    localparam logic [MUL_B_W-1:0] C1_SCALED = 20'd65025;
    localparam logic [MUL_B_W-1:0] C2_SCALED = 20'd585225;
    localparam logic [MUL_B_W-1:0] SCALE     = 20'd10000;
    localparam logic [MUL_B_W-1:0] SCALE2    = 20'd20000;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sx;
        logic [SUM_W-1:0] sy;
        logic [SQ_W-1:0]  sxx;
        logic [SQ_W-1:0]  syy;
        logic [SQ_W-1:0]  sxy;
        logic             ovf;
    } swc_sums_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } swc_div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quo;
    } swc_div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/swc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pixel pair stream
interface swc_pix_if import swc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] image_pixel;
    logic [PIX_W-1:0] glyph_pixel;
    logic             last_pixel;

    modport source (output valid, image_pixel, glyph_pixel, last_pixel, input ready);
    modport sink   (input valid, image_pixel, glyph_pixel, last_pixel, output ready);
endinterface

// Similarity result stream
interface swc_res_if import swc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [SIM_W-1:0] similarity;
    logic                    window_overflow;

    modport source (output valid, similarity, window_overflow, input ready);
    modport sink   (input valid, similarity, window_overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/swc_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swc_accum import swc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic             clear,
    input  logic [PIX_W-1:0] image_pixel,
    input  logic [PIX_W-1:0] glyph_pixel,
    output swc_sums_t        sums
);

    swc_sums_t            sums_reg;
    swc_sums_t            sums_next;
    logic [2*PIX_W-1:0]   xx;
    logic [2*PIX_W-1:0]   yy;
    logic [2*PIX_W-1:0]   xy;

    // Per-beat products
    assign xx = image_pixel * image_pixel;
    assign yy = glyph_pixel * glyph_pixel;
    assign xy = image_pixel * glyph_pixel;

    // Clear, accumulate, or hold and flag once the window is full
    always_comb
    begin
        sums_next = sums_reg;
        if (clear)
        begin
            sums_next = '0;
        end
        else if (take)
        begin
            if (sums_reg.count >= CNT_W'(MAX_PIXELS))
            begin
                sums_next.ovf = 1'b1;
            end
            else
            begin
                sums_next.sx    = sums_reg.sx + SUM_W'(image_pixel);
                sums_next.sy    = sums_reg.sy + SUM_W'(glyph_pixel);
                sums_next.sxx   = sums_reg.sxx + SQ_W'(xx);
                sums_next.syy   = sums_reg.syy + SQ_W'(yy);
                sums_next.sxy   = sums_reg.sxy + SQ_W'(xy);
                sums_next.count = sums_reg.count + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg <= '0;
        end
        else
        begin
            sums_reg <= sums_next;
        end
    end

    assign sums = sums_reg;

endmodule

`default_nettype wire

// ===== rtl/swc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swc_div import swc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  swc_div_req_t req,
    output swc_div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_DIV_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     den_reg;
    logic [Q_W-1:0]       quo_reg;
    logic [DIV_W:0]       rem_sh;
    logic [DIV_W:0]       rem_sub;
    logic                 fits;
    logic                 sat;

    // One restoring step per cycle
    assign rem_sh  = {rem_reg, 1'b0};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = rem_sh >= {1'b0, den_reg};
    // Ratio of 1.0 or more is limited to 1.0 at once
    assign sat     = req.num >= req.den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= !sat;
            done_reg <= sat;
            cnt_reg  <= CNT_DIV_W'(Q_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_DIV_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num;
            den_reg <= req.den;
            quo_reg <= sat ? Q_ONE : '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            quo_reg <= {quo_reg[Q_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/swc_final.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swc_final import swc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  swc_sums_t    sums,
    input  swc_div_rsp_t div_rsp,
    output swc_div_req_t div_req,
    output logic         idle,
    output logic         clear,
    swc_res_if.source    results
);

    typedef enum logic [23:0] {
        S_IDLE = 24'h000001,
        S_N2   = 24'h000002,
        S_XX   = 24'h000004,
        S_XSQ  = 24'h000008,
        S_YY   = 24'h000010,
        S_YSQ  = 24'h000020,
        S_XY   = 24'h000040,
        S_XYS  = 24'h000080,
        S_MC1  = 24'h000100,
        S_MC2  = 24'h000200,
        S_L1   = 24'h000400,
        S_L2   = 24'h000800,
        S_L3   = 24'h001000,
        S_L4   = 24'h002000,
        S_L5   = 24'h004000,
        S_DLS  = 24'h008000,
        S_DLW  = 24'h010000,
        S_DCS  = 24'h020000,
        S_DCW  = 24'h040000,
        S_P1   = 24'h080000,
        S_P2   = 24'h100000,
        S_P3   = 24'h200000,
        S_RND  = 24'h400000,
        S_OUT  = 24'h800000
    } swc_state_t;

    swc_state_t                state_reg;
    swc_state_t                state_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [SIM_W-1:0]          out_sim_reg;
    logic                      out_ovf_reg;
    logic                      load;

    // Shared multiplier
    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic [MUL_P_W-1:0]        mul_full;
    logic [PROD_W-1:0]         prod_reg;

    // Window statistics
    logic [N2_W-1:0]           n2_reg;
    logic signed [VAR_W-1:0]   vx_reg;
    logic signed [VAR_W-1:0]   vy_reg;
    logic signed [VAR_W-1:0]   cv_reg;
    logic signed [VAR_W-1:0]   prod_var;
    logic [MUL_A_W-1:0]        sqs_reg;
    logic [MUL_A_W-1:0]        sxsy_reg;
    logic [MUL_A_W-1:0]        vsum_reg;
    logic [MUL_A_W-1:0]        cv_mag;

    // Ratio terms
    logic [DIV_W-1:0]          c1n2_reg;
    logic [DIV_W-1:0]          c2n2_reg;
    logic [DIV_W-1:0]          lnum_reg;
    logic [DIV_W-1:0]          lden_reg;
    logic [DIV_W-1:0]          cmag_reg;
    logic [DIV_W-1:0]          cden_reg;
    logic                      cneg_reg;
    logic [DIV_W:0]            cnum_s;
    logic [DIV_W:0]            cnum_negv;
    logic [DIV_W-1:0]          cmag;

    // Quotients, product and rounding
    logic [Q_W-1:0]            lq_reg;
    logic [Q_W-1:0]            cq_reg;
    logic [PACC_W-1:0]         pacc_reg;
    logic [PACC_W:0]           rsum;
    logic [MAGX_W-1:0]         mag_x;
    logic [MAGX_W-1:0]         mag_neg;
    logic [SIM_W-1:0]          sim_val;
    logic [SIM_W-1:0]          sim_reg;

    assign mul_full = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    assign prod_var = $signed({1'b0, prod_reg[VAR_W-2:0]});
    assign cv_mag   = cv_reg[VAR_W-1] ? MUL_A_W'(-cv_reg) : MUL_A_W'(cv_reg);

    // Contrast-structure numerator, signed
    assign cnum_s    = cv_reg[VAR_W-1] ? ({1'b0, c2n2_reg} - {1'b0, DIV_W'(prod_reg)})
                                       : ({1'b0, c2n2_reg} + {1'b0, DIV_W'(prod_reg)});
    assign cnum_negv = '0 - cnum_s;
    assign cmag      = cnum_s[DIV_W] ? cnum_negv[DIV_W-1:0] : cnum_s[DIV_W-1:0];

    // Round half away from zero on the magnitude, then saturate
    assign rsum    = {1'b0, pacc_reg} + RND_HALF;
    assign mag_x   = MAGX_W'(rsum >> RND_SH);
    assign mag_neg = '0 - mag_x;

    always_comb
    begin
        if (!cneg_reg)
        begin
            sim_val = (mag_x > SIM_POS_LIM) ? {1'b0, {(SIM_W-1){1'b1}}} : mag_x[SIM_W-1:0];
        end
        else
        begin
            sim_val = (mag_x > SIM_NEG_LIM) ? {1'b1, {(SIM_W-1){1'b0}}} : mag_neg[SIM_W-1:0];
        end
    end

    // Sequencer: operand select and next state
    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_req    = '0;
        load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_N2;
                end
            end
            S_N2:
            begin
                mul_a      = MUL_A_W'(sums.count);
                mul_b      = MUL_B_W'(sums.count);
                state_next = S_XX;
            end
            S_XX:
            begin
                mul_a      = MUL_A_W'(sums.sxx);
                mul_b      = MUL_B_W'(sums.count);
                state_next = S_XSQ;
            end
            S_XSQ:
            begin
                mul_a      = MUL_A_W'(sums.sx);
                mul_b      = MUL_B_W'(sums.sx);
                state_next = S_YY;
            end
            S_YY:
            begin
                mul_a      = MUL_A_W'(sums.syy);
                mul_b      = MUL_B_W'(sums.count);
                state_next = S_YSQ;
            end
            S_YSQ:
            begin
                mul_a      = MUL_A_W'(sums.sy);
                mul_b      = MUL_B_W'(sums.sy);
                state_next = S_XY;
            end
            S_XY:
            begin
                mul_a      = MUL_A_W'(sums.sxy);
                mul_b      = MUL_B_W'(sums.count);
                state_next = S_XYS;
            end
            S_XYS:
            begin
                mul_a      = MUL_A_W'(sums.sx);
                mul_b      = MUL_B_W'(sums.sy);
                state_next = S_MC1;
            end
            S_MC1:
            begin
                mul_a      = MUL_A_W'(n2_reg);
                mul_b      = C1_SCALED;
                state_next = S_MC2;
            end
            S_MC2:
            begin
                mul_a      = MUL_A_W'(n2_reg);
                mul_b      = C2_SCALED;
                state_next = S_L1;
            end
            S_L1:
            begin
                mul_a      = sxsy_reg;
                mul_b      = SCALE2;
                state_next = S_L2;
            end
            S_L2:
            begin
                mul_a      = sqs_reg;
                mul_b      = SCALE;
                state_next = S_L3;
            end
            S_L3:
            begin
                mul_a      = cv_mag;
                mul_b      = SCALE2;
                state_next = S_L4;
            end
            S_L4:
            begin
                mul_a      = vsum_reg;
                mul_b      = SCALE;
                state_next = S_L5;
            end
            S_L5:
            begin
                state_next = S_DLS;
            end
            S_DLS:
            begin
                div_req.start = 1'b1;
                div_req.num   = lnum_reg;
                div_req.den   = lden_reg;
                state_next    = S_DLW;
            end
            S_DLW:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DCS;
                end
            end
            S_DCS:
            begin
                div_req.start = 1'b1;
                div_req.num   = cmag_reg;
                div_req.den   = cden_reg;
                state_next    = S_DCW;
            end
            S_DCW:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_P1;
                end
            end
            S_P1:
            begin
                mul_a      = MUL_A_W'(lq_reg);
                mul_b      = cq_reg[MUL_B_W-1:0];
                state_next = S_P2;
            end
            S_P2:
            begin
                mul_a      = MUL_A_W'(lq_reg);
                mul_b      = MUL_B_W'(cq_reg[Q_W-1:MUL_B_W]);
                state_next = S_P3;
            end
            S_P3:
            begin
                state_next = S_RND;
            end
            S_RND:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                load = !out_valid_reg || results.ready;
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle  = (state_reg == S_IDLE);
    assign clear = load;

    // Output register holds a beat until taken
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers, written by step
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[PROD_W-1:0];
        case (state_reg)
            S_XX:
            begin
                n2_reg <= prod_reg[N2_W-1:0];
            end
            S_XSQ:
            begin
                vx_reg <= prod_var;
            end
            S_YY:
            begin
                vx_reg  <= vx_reg - prod_var;
                sqs_reg <= prod_reg[MUL_A_W-1:0];
            end
            S_YSQ:
            begin
                vy_reg <= prod_var;
            end
            S_XY:
            begin
                vy_reg  <= vy_reg - prod_var;
                sqs_reg <= sqs_reg + prod_reg[MUL_A_W-1:0];
            end
            S_XYS:
            begin
                cv_reg <= prod_var;
            end
            S_MC1:
            begin
                cv_reg   <= cv_reg - prod_var;
                sxsy_reg <= prod_reg[MUL_A_W-1:0];
            end
            S_MC2:
            begin
                c1n2_reg <= prod_reg[DIV_W-1:0];
                // variances below zero read as zero
                if (vx_reg[VAR_W-1])
                begin
                    vx_reg <= '0;
                end
                if (vy_reg[VAR_W-1])
                begin
                    vy_reg <= '0;
                end
            end
            S_L1:
            begin
                c2n2_reg <= prod_reg[DIV_W-1:0];
                vsum_reg <= MUL_A_W'(vx_reg[VAR_W-2:0]) + MUL_A_W'(vy_reg[VAR_W-2:0]);
            end
            S_L2:
            begin
                lnum_reg <= DIV_W'(prod_reg) + c1n2_reg;
            end
            S_L3:
            begin
                lden_reg <= DIV_W'(prod_reg) + c1n2_reg;
            end
            S_L4:
            begin
                cmag_reg <= cmag;
                cneg_reg <= cnum_s[DIV_W];
            end
            S_L5:
            begin
                cden_reg <= DIV_W'(prod_reg) + c2n2_reg;
            end
            S_DLW:
            begin
                if (div_rsp.done)
                begin
                    lq_reg <= div_rsp.quo;
                end
            end
            S_DCW:
            begin
                if (div_rsp.done)
                begin
                    cq_reg <= div_rsp.quo;
                end
            end
            S_P2:
            begin
                pacc_reg <= PACC_W'(prod_reg);
            end
            S_P3:
            begin
                pacc_reg <= pacc_reg + (PACC_W'(prod_reg) << MUL_B_W);
            end
            S_RND:
            begin
                sim_reg <= sim_val;
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            out_sim_reg <= sim_reg;
            out_ovf_reg <= sums.ovf;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.similarity      = $signed(out_sim_reg);
    assign results.window_overflow = out_ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/ssim_window_compare_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-window SSIM of an image window against a glyph. Pixel pairs are
// taken one beat per cycle while the window accumulates; the beat flagged
// last_pixel closes the window and starts the final evaluation, during which
// the pixel port is not ready. The evaluation spends 13 steps on the shared
// 42x20 multiplier for the moments and ratio terms, then settles the last
// sum. It then makes two runs of the shared one-bit-per-cycle divider; a
// ratio at or above 1.0 cuts its run short. It ends with the two-part
// product, the merge, rounding and the output load. The result is signed
// Q1.14 with 16384 = 1.0. Pairs beyond 4096 in a window are dropped and
// flagged with window_overflow. The result sits in an output register, so
// the next window can be fed while it waits to be taken. The load at the
// end of the evaluation waits only while the previous result is still
// held there.
module ssim_window_compare_core import swc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    swc_pix_if.sink   pixels,
    swc_res_if.source results
);

    logic         take;
    logic         start;
    logic         clear;
    logic         idle;
    swc_sums_t    sums;
    swc_div_req_t div_req;
    swc_div_rsp_t div_rsp;

    // Pixel beats are taken only between windows' evaluations
    assign pixels.ready = idle;
    assign take         = pixels.valid & idle;
    assign start        = take & pixels.last_pixel;

    swc_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .clear       (clear),
        .image_pixel (pixels.image_pixel),
        .glyph_pixel (pixels.glyph_pixel),
        .sums        (sums)
    );

    swc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    swc_final u_final (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .sums    (sums),
        .div_rsp (div_rsp),
        .div_req (div_req),
        .idle    (idle),
        .clear   (clear),
        .results (results)
    );

endmodule

`default_nettype wire
